@@ design/spq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared constants, entry type and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int FIELD_W  = 10;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] aux;
  } spq_entry_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch;
    logic       res_init;
    logic [1:0] res_status;
    logic       scan_start;
    logic       scan_shift;
    logic       scan_stop;
    logic       pos_zero;
    logic       place;
    logic       pop_read;
    logic       pop_take;
    logic       clear;
    logic       emit;
  } spq_ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       shift;
    logic       last;
    logic       out_free;
  } spq_stat_t;

endpackage
`default_nettype wire

@@ design/sorted_priority_queue_top.sv @@
`default_nettype none
// Flow: clear, pop on empty, full insert and unknown codes go from decode
// straight to the result hand-off; a pop first reads the head slot; an insert
// scans back over the stored entries (at most CAPACITY - 1) and then places.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. The scan rate is set by the slot memory: one read, one write a cycle.
// Reset (rst, synchronous): queue empty, no result pending; slots keep garbage.
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// Bounded queue kept in descending key order, with insert, pop and clear.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  command,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_id,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_key,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_aux,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [spq_pkg::FIELD_W-1:0]      head_id,
  output logic [spq_pkg::FIELD_W-1:0]      head_key,
  output logic [spq_pkg::FIELD_W-1:0]      head_aux,
  output logic [spq_pkg::FILL_W-1:0]       fill_level
);
  import spq_pkg::*;

  // The slots form a ring: the head pointer advances on pop, so popping never
  // moves data. An insert walks backwards from the tail, one slot a cycle,
  // moving each entry one place down while its key does not beat the new key
  // (for the head itself the new key must be strictly greater), then drops the
  // new entry into the gap left behind.
  spq_ctrl_t ctl;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Hold the result in the output register until taken; the controller waits
  // in its hand-off state only if the previous result is still there.
  spq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .command    (command),
    .entry_id   (entry_id),
    .entry_key  (entry_key),
    .entry_aux  (entry_aux),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .status     (status),
    .head_id    (head_id),
    .head_key   (head_key),
    .head_aux   (head_aux),
    .fill_level (fill_level)
  );

  // The fill level never exceeds the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_level <= FILL_W'(CAPACITY)))
    else $error("fill level above capacity");

  // A dropped insert is reported only on a full queue.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (fill_level == FILL_W'(CAPACITY)))
    else $error("insert dropped on a queue that is not full");

  // A pop on an empty queue leaves it empty and returns zero fields.
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |->
      (fill_level == '0 && head_id == '0 && head_key == '0 && head_aux == '0))
    else $error("empty pop returned data");

  // One item at a time: acceptance closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule
`default_nettype wire

@@ design/spq_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue datapath
// Circular slot memory, scan/shift registers, result and output registers.
// ----------------------------------------------------------------------------
module spq_dpath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire spq_pkg::spq_ctrl_t         ctl,
  output spq_pkg::spq_stat_t              stat,
  input  wire logic [1:0]                 command,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_id,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_key,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_aux,
  input  wire logic                       out_ready,
  output logic                            out_valid,
  output logic [1:0]                      status,
  output logic [spq_pkg::FIELD_W-1:0]     head_id,
  output logic [spq_pkg::FIELD_W-1:0]     head_key,
  output logic [spq_pkg::FIELD_W-1:0]     head_aux,
  output logic [spq_pkg::FILL_W-1:0]      fill_level
);
  import spq_pkg::*;

  // physical slot for a logical offset from the head, wrapping at CAPACITY
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] ofs);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (ADDR_W+1)'(CAPACITY)) s = s - (ADDR_W+1)'(CAPACITY);
    return s[ADDR_W-1:0];
  endfunction

  spq_entry_t          slots [CAPACITY];
  spq_entry_t          rd_data;
  spq_entry_t          new_entry;
  spq_entry_t          res_entry;
  logic [1:0]          cmd_code;
  logic [1:0]          res_status;
  logic [FILL_W-1:0]   occ;
  logic [FILL_W-1:0]   occ_m1;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   scan_idx;
  logic [ADDR_W-1:0]   pos;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   waddr;
  logic [ADDR_W-1:0]   raddr;
  spq_entry_t          wdata;

  assign occ_m1 = occ - FILL_W'(1);

  // memory port selection
  always_comb begin
    mem_re = ctl.scan_start | ctl.scan_shift | ctl.pop_read;
    mem_we = ctl.scan_shift | ctl.place;
    raddr  = head;
    if (ctl.scan_start) begin
      raddr = phys(head, occ_m1[ADDR_W-1:0]);
    end else if (ctl.scan_shift) begin
      raddr = phys(head, scan_idx - ADDR_W'(1));
    end
    if (ctl.scan_shift) begin
      waddr = phys(head, scan_idx + ADDR_W'(1));
      wdata = rd_data;
    end else begin
      waddr = phys(head, pos);
      wdata = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) slots[waddr] <= wdata;
    if (mem_re) rd_data <= slots[raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_code      <= command;
      new_entry.id  <= entry_id;
      new_entry.key <= entry_key;
      new_entry.aux <= entry_aux;
    end
    if (ctl.scan_start) scan_idx <= occ_m1[ADDR_W-1:0];
    if (ctl.scan_shift) begin
      scan_idx <= scan_idx - ADDR_W'(1);
      pos      <= scan_idx;
    end
    if (ctl.scan_stop) pos <= scan_idx + ADDR_W'(1);
    if (ctl.pos_zero) pos <= '0;
    if (ctl.res_init) begin
      res_status <= ctl.res_status;
      res_entry  <= '0;
    end
    if (ctl.pop_take) res_entry <= rd_data;
    if (ctl.emit) begin
      status     <= res_status;
      head_id    <= res_entry.id;
      head_key   <= res_entry.key;
      head_aux   <= res_entry.aux;
      fill_level <= occ;
    end
  end

  // queue control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        occ <= '0;
      end else if (ctl.place) begin
        occ <= occ + FILL_W'(1);
      end else if (ctl.pop_take) begin
        occ  <= occ_m1;
        head <= phys(head, ADDR_W'(1));
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // status back to the controller
  always_comb begin
    stat.cmd      = cmd_code;
    stat.empty    = (occ == '0);
    stat.full     = (occ == FILL_W'(CAPACITY));
    stat.last     = (scan_idx == '0);
    stat.shift    = stat.last ? (rd_data.key <  new_entry.key)
                              : (rd_data.key <= new_entry.key);
    stat.out_free = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

@@ design/spq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue controller
// Sequences decode, backward scan/shift, placement, pop and result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_ctrl_t      ctl
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PLACE  = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl            = '0;
    ctl.res_status = ST_OK;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        ctl.res_init = 1'b1;
        state_next   = S_EMIT;
        case (stat.cmd)
          CMD_INSERT: begin
            if (stat.full) begin
              ctl.res_status = ST_FULL;
            end else if (stat.empty) begin
              ctl.pos_zero = 1'b1;
              state_next   = S_PLACE;
            end else begin
              ctl.scan_start = 1'b1;
              state_next     = S_SCAN;
            end
          end
          CMD_POP: begin
            if (stat.empty) begin
              ctl.res_status = ST_EMPTY;
            end else begin
              ctl.pop_read = 1'b1;
              state_next   = S_POP;
            end
          end
          CMD_CLEAR: begin
            ctl.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (stat.shift) begin
          ctl.scan_shift = 1'b1;
          if (stat.last) state_next = S_PLACE;
        end else begin
          ctl.scan_stop = 1'b1;
          state_next    = S_PLACE;
        end
      end
      S_PLACE: begin
        ctl.place  = 1'b1;
        state_next = S_EMIT;
      end
      S_POP: begin
        ctl.pop_take = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ test/spq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Watches both channels and keeps its own image of the queue. Each accepted
// command is turned into the reply it should produce. Each reply that leaves
// the block is compared with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module spq_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [1:0]                  command,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_id,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_key,
  input  wire logic [spq_pkg::FIELD_W-1:0] entry_aux,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [1:0]                  status,
  input  wire logic [spq_pkg::FIELD_W-1:0] head_id,
  input  wire logic [spq_pkg::FIELD_W-1:0] head_key,
  input  wire logic [spq_pkg::FIELD_W-1:0] head_aux,
  input  wire logic [spq_pkg::FILL_W-1:0]  fill_level,
  output int                               fail_count,
  output int                               outstanding
);
  import spq_pkg::*;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] id;
    logic [FIELD_W-1:0] key;
    logic [FIELD_W-1:0] aux;
    logic [FILL_W-1:0]  fill;
  } reply_t;

  spq_entry_t queue_image [CAPACITY];
  int         image_fill;
  reply_t     awaited_replies [$];
  int         mismatches;

  // Apply one command to the queue image and return the reply it produces.
  function automatic reply_t apply_command(input logic [1:0] cmd, input spq_entry_t ent);
    reply_t r;
    int     pos;
    r = '0;
    case (cmd)
      CMD_INSERT: begin
        if (image_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // the head is displaced only by a strictly greater key
          pos = 0;
          if (image_fill != 0 && ent.key <= queue_image[0].key) begin
            pos = 1;
            while (pos < image_fill && ent.key < queue_image[pos].key) pos++;
          end
          for (int i = image_fill; i > pos; i--) queue_image[i] = queue_image[i-1];
          queue_image[pos] = ent;
          image_fill++;
        end
      end
      CMD_POP: begin
        if (image_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id  = queue_image[0].id;
          r.key = queue_image[0].key;
          r.aux = queue_image[0].aux;
          for (int i = 1; i < image_fill; i++) queue_image[i-1] = queue_image[i];
          image_fill--;
        end
      end
      CMD_CLEAR: begin
        image_fill = 0;
      end
      default: begin
      end
    endcase
    r.fill = FILL_W'(image_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      image_fill = 0;
      awaited_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {status, head_id, head_key, head_aux, fill_level};
        if (awaited_replies.size() == 0) begin
          if (mismatches < 10)
            $display("chk: unexpected reply status=%0d id=%0d key=%0d aux=%0d fill=%0d",
                     got.status, got.id, got.key, got.aux, got.fill);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"chk: reply mismatch: expected status=%0d id=%0d key=%0d aux=%0d ",
                        "fill=%0d, got status=%0d id=%0d key=%0d aux=%0d fill=%0d"},
                       want.status, want.id, want.key, want.aux, want.fill,
                       got.status, got.id, got.key, got.aux, got.fill);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_replies.push_back(apply_command(command, {entry_id, entry_key, entry_aux}));
    end
    fail_count  <= mismatches;
    outstanding <= awaited_replies.size();
  end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert, pop, clear and spare commands into the queue with random
// idling on both channels; a checker beside the block predicts every reply.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  // the one command code the block ignores
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int FIELD_MAX     = (1 << FIELD_W) - 1;
  localparam int RANDOM_ITEMS  = 800;
  // items at the tail of the run sent with no idling on either side
  localparam int CALM_TAIL     = 120;
  // margin left after the last reply for stray replies
  localparam int SETTLE_CYCLES = 100;
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT   = 2000;

  // spread of keys within a phase
  localparam int KEYS_NARROW  = 0;
  localparam int KEYS_FULL    = 1;
  localparam int KEYS_EXTREME = 2;

  // mix of commands within a phase
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_EVEN  = 2;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [1:0]         command   = CMD_INSERT;
  logic [FIELD_W-1:0] entry_id  = '0;
  logic [FIELD_W-1:0] entry_key = '0;
  logic [FIELD_W-1:0] entry_aux = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [FIELD_W-1:0] head_id;
  logic [FIELD_W-1:0] head_key;
  logic [FIELD_W-1:0] head_aux;
  logic [FILL_W-1:0]  fill_level;

  int fail_count;
  int outstanding;

  // idling on both channels is allowed only while this is set
  logic idle_on     = 1'b1;
  int   stall_left  = 0;
  int   quiet_cycles = 0;

  sorted_priority_queue_top dut (.*);
  spq_checker               chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: hold out_ready low in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until the block takes it. An optional gap
  // goes in front; otherwise valid stays high straight into the next item so
  // that back-to-back offers are exercised.
  task automatic send_item(input logic [1:0] cmd, input int id, input int key, input int aux);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= cmd;
    entry_id  <= FIELD_W'(id);
    entry_key <= FIELD_W'(key);
    entry_aux <= FIELD_W'(aux);
    do @(posedge clk); while (!in_ready);
  endtask

  // Narrow spreads give many equal keys, extreme ones hit the field limits.
  function automatic int pick_key(input int spread);
    case (spread)
      KEYS_NARROW:  return $urandom_range(0, 3);
      KEYS_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 0;
          1:       return 1;
          2:       return FIELD_MAX - 1;
          default: return FIELD_MAX;
        endcase
      end
      default:      return $urandom_range(0, FIELD_MAX);
    endcase
  endfunction

  initial begin
    int         sent;
    int         mix;
    int         spread;
    int         span;
    int         insert_pct;
    int         roll;
    logic       phase_idle;
    logic [1:0] cmd;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty pop, head and tail ties, field extremes,
    // the spare code, a full drain, and clear on a loaded and an empty queue.
    send_item(CMD_POP,    FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(CMD_INSERT, 0,         0,         0);
    send_item(CMD_INSERT, FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(CMD_INSERT, 5,         FIELD_MAX, 0);          // ties the head: goes behind
    send_item(CMD_INSERT, 7,         0,         FIELD_MAX);  // ties the tail
    send_item(CMD_INSERT, 9,         512,       341);
    send_item(CMD_INSERT, 682,       1,         682);
    send_item(CMD_SPARE,  FIELD_MAX, FIELD_MAX, FIELD_MAX);
    repeat (6) send_item(CMD_POP, 0, 0, 0);
    send_item(CMD_POP,    0,         0,         0);          // empty again
    send_item(CMD_INSERT, 21,        300,       22);
    send_item(CMD_INSERT, 23,        300,       24);
    send_item(CMD_CLEAR,  FIELD_MAX, FIELD_MAX, FIELD_MAX);
    send_item(CMD_CLEAR,  0,         0,         0);
    send_item(CMD_INSERT, 31,        FIELD_MAX, 32);
    send_item(CMD_POP,    0,         0,         0);

    // Random part in phases: fill phases push the queue to full and beyond,
    // drain phases run it dry, even phases stir the middle. The first phase
    // always fills far enough to hit the full case.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix    = (sent == 0) ? MIX_FILL : $urandom_range(MIX_FILL, MIX_EVEN);
      spread = $urandom_range(KEYS_NARROW, KEYS_EXTREME);
      span   = (sent == 0) ? 90 : $urandom_range(40, 100);
      case (mix)
        MIX_FILL:  insert_pct = 92;
        MIX_DRAIN: insert_pct = 10;
        default:   insert_pct = 55;
      endcase
      // leave some phases free of idling
      phase_idle = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < span && sent < RANDOM_ITEMS; n++) begin
        // no idling at all in the calm tail
        idle_on <= phase_idle && (RANDOM_ITEMS - sent > CALM_TAIL);
        roll = $urandom_range(0, 99);
        if (roll == 0)
          cmd = CMD_SPARE;
        else if (mix == MIX_EVEN && roll < 3)
          cmd = CMD_CLEAR;
        else if (roll < insert_pct)
          cmd = CMD_INSERT;
        else
          cmd = CMD_POP;
        send_item(cmd, $urandom_range(0, FIELD_MAX), pick_key(spread),
                  $urandom_range(0, FIELD_MAX));
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every awaited reply, then allow time for strays.
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ sorted_priority_queue_top.f @@
design/spq_pkg.sv
design/spq_dpath.sv
design/spq_ctrl.sv
design/sorted_priority_queue_top.sv
test/spq_checker.sv
test/tb_top.sv
